@@ rtl/ust_pkg.sv @@
// shared types and codes for the unread summary table
`default_nettype none

package ust_pkg;

   // request codes, the upper three codes of the field are unused
   localparam logic [2:0] OP_ARRIVE = 3'd0;
   localparam logic [2:0] OP_CLEAR  = 3'd1;
   localparam logic [2:0] OP_COUNT  = 3'd2;
   localparam logic [2:0] OP_BADGE  = 3'd3;
   localparam logic [2:0] OP_DELETE = 3'd4;

   // response status codes
   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] group_id;
      logic [31:0] contact_id;
      logic [7:0]  badge_bits;
      logic        conversation_open;
      logic        was_unread;
   } request_type;

   // prefix flags rippled along the row during the scan cycle
   typedef struct packed {
      logic hit;
      logic inv;
      logic zero;
   } scan_type;

   // results gathered along the row during the apply cycle
   typedef struct packed {
      logic [15:0] count;
      logic        badge;
      logic        deleted;
   } apply_type;

   // per-cell status seen by the top level
   typedef struct packed {
      logic hit;
      logic sel;
   } cell_flags_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

endpackage

`default_nettype wire

@@ rtl/ust_if.sv @@
// request and response channel interfaces
`default_nettype none

interface ust_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [15:0] group_id;
   logic [31:0] contact_id;
   logic [7:0]  badge_bits;
   logic        conversation_open;
   logic        was_unread;

   modport source (
      output valid, req_type, group_id, contact_id, badge_bits, conversation_open,
             was_unread,
      input  ready
   );
   modport sink (
      input  valid, req_type, group_id, contact_id, badge_bits, conversation_open,
             was_unread,
      output ready
   );
endinterface

interface ust_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] msg_count;
   logic        badge_present;
   logic [1:0]  status;

   modport source (
      output valid, msg_count, badge_present, status,
      input  ready
   );
   modport sink (
      input  valid, msg_count, badge_present, status,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/ust_cell.sv @@
// one table entry with its match logic and neighbor links
`default_nettype none

module ust_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ust_pkg::request_type    req,
   input  wire logic                    scan_en,
   input  wire logic                    commit,
   input  wire ust_pkg::scan_type       scan_total,
   input  wire ust_pkg::scan_type       scan_in,
   output      ust_pkg::scan_type       scan_out,
   input  wire ust_pkg::apply_type      apply_in,
   output      ust_pkg::apply_type      apply_out,
   output      ust_pkg::cell_flags_type flags
);

   logic        valid_ff, valid_in;
   logic [15:0] group_ff, group_in;
   logic [31:0] contact_ff, contact_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  badges_ff, badges_in;

   logic hit_ff, grp_ff, hit_first_ff, inv_first_ff, zero_first_ff;

   logic        hit_now, grp_now, is_arrive, is_lookup, sel, badge_now;
   logic [15:0] base_count, new_count;
   logic [7:0]  base_badges;

   always_comb begin
      hit_now = valid_ff && (group_ff == req.group_id) && (contact_ff == req.contact_id);
      grp_now = valid_ff && (group_ff == req.group_id);

      scan_out.hit  = scan_in.hit | hit_now;
      scan_out.inv  = scan_in.inv | !valid_ff;
      scan_out.zero = scan_in.zero | (count_ff == '0);
   end

   // local flags and first-in-row marks, taken in the scan cycle
   always_ff @(posedge clock) begin
      if (scan_en) begin
         hit_ff        <= hit_now;
         grp_ff        <= grp_now;
         hit_first_ff  <= hit_now && !scan_in.hit;
         inv_first_ff  <= !valid_ff && !scan_in.inv;
         zero_first_ff <= (count_ff == '0) && !scan_in.zero;
      end
   end

   always_comb begin
      is_arrive = (req.req_type == ust_pkg::OP_ARRIVE) && !req.conversation_open;
      is_lookup = (req.req_type == ust_pkg::OP_CLEAR) || (req.req_type == ust_pkg::OP_COUNT);

      if (is_arrive) begin
         if (scan_total.hit) begin
            sel = hit_first_ff;
         end else if (scan_total.inv) begin
            sel = inv_first_ff;
         end else begin
            sel = zero_first_ff;
         end
      end else if (is_lookup) begin
         sel = hit_first_ff;
      end else begin
         sel = 1'b0;
      end

      // a claimed entry starts from a zero count and no badges
      base_count  = (is_arrive && !scan_total.hit) ? '0 : count_ff;
      base_badges = (is_arrive && !scan_total.hit) ? '0 : badges_ff;

      if (is_arrive) begin
         new_count = (base_count == ust_pkg::COUNT_MAX) ? base_count : base_count + 16'd1;
      end else if ((req.req_type == ust_pkg::OP_CLEAR) && req.was_unread) begin
         new_count = (count_ff == '0) ? count_ff : count_ff - 16'd1;
      end else begin
         new_count = count_ff;
      end

      badge_now = (req.req_type == ust_pkg::OP_BADGE) && valid_ff && (count_ff != '0)
                  && ((badges_ff & req.badge_bits) != '0);

      apply_out.count   = apply_in.count | (sel ? new_count : 16'd0);
      apply_out.badge   = apply_in.badge | badge_now;
      apply_out.deleted = apply_in.deleted | ((req.req_type == ust_pkg::OP_DELETE) && grp_ff);

      flags.hit = hit_ff;
      flags.sel = sel;

      valid_in   = valid_ff;
      group_in   = group_ff;
      contact_in = contact_ff;
      count_in   = count_ff;
      badges_in  = badges_ff;
      if (commit) begin
         if (sel) begin
            count_in = new_count;
            if (is_arrive) begin
               valid_in   = 1'b1;
               group_in   = req.group_id;
               contact_in = req.contact_id;
               badges_in  = base_badges | req.badge_bits;
            end
         end
         if ((req.req_type == ust_pkg::OP_DELETE) && grp_ff) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         group_ff   <= '0;
         contact_ff <= '0;
         count_ff   <= '0;
         badges_ff  <= '0;
      end else begin
         valid_ff   <= valid_in;
         group_ff   <= group_in;
         contact_ff <= contact_in;
         count_ff   <= count_in;
         badges_ff  <= badges_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/unread_summary_table_top.sv @@
// top level of the unread summary table: sequencer and row of entry cells
// order: the request is held, the row is scanned in the scan state, and the apply
//   state commits the cells and loads the response register; a new request is
//   taken only when idle or as the previous one commits
// reset: synchronous, clears every entry and the response valid flag
`default_nettype none

module unread_summary_table_top #(
   parameter int TABLE_ENTRIES = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   ust_req_if.sink   req_chan,
   ust_rsp_if.source rsp_chan
);

   ust_pkg::state_type   state_ff, state_in;
   ust_pkg::request_type req_ff, req_in;
   ust_pkg::scan_type    total_ff, total_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_count_ff, rsp_count_in;
   logic        rsp_badge_ff, rsp_badge_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic req_ready, accept, scan_en, commit;

   // neighbor links along the row, element zero is the row entrance
   ust_pkg::scan_type       scan_chain  [TABLE_ENTRIES+1];
   ust_pkg::apply_type      apply_chain [TABLE_ENTRIES+1];
   ust_pkg::cell_flags_type cell_flags  [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] hit_vec, sel_vec;

   assign scan_chain[0]  = '0;
   assign apply_chain[0] = '0;

   // one cell per entry, all share the held request
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      ust_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .req        (req_ff),
         .scan_en    (scan_en),
         .commit     (commit),
         .scan_total (total_ff),
         .scan_in    (scan_chain[i]),
         .scan_out   (scan_chain[i+1]),
         .apply_in   (apply_chain[i]),
         .apply_out  (apply_chain[i+1]),
         .flags      (cell_flags[i])
      );
      assign hit_vec[i] = cell_flags[i].hit;
      assign sel_vec[i] = cell_flags[i].sel;
   end

   // sequencer: idle, scan the row for flags, apply and load the response
   always_comb begin
      scan_en   = (state_ff == ust_pkg::ST_SCAN);
      // apply waits while an older response has not been taken
      commit    = (state_ff == ust_pkg::ST_APPLY) && (!rsp_valid_ff || rsp_chan.ready);
      req_ready = (state_ff == ust_pkg::ST_IDLE) || commit;
      accept    = req_chan.valid && req_ready;

      state_in = state_ff;
      unique case (state_ff)
         ust_pkg::ST_IDLE: begin
            if (accept) state_in = ust_pkg::ST_SCAN;
         end
         ust_pkg::ST_SCAN: begin
            state_in = ust_pkg::ST_APPLY;
         end
         ust_pkg::ST_APPLY: begin
            if (commit) state_in = accept ? ust_pkg::ST_SCAN : ust_pkg::ST_IDLE;
         end
         default: begin
            state_in = ust_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ust_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request hold and row totals
   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in.req_type          = req_chan.req_type;
         req_in.group_id          = req_chan.group_id;
         req_in.contact_id        = req_chan.contact_id;
         req_in.badge_bits        = req_chan.badge_bits;
         req_in.conversation_open = req_chan.conversation_open;
         req_in.was_unread        = req_chan.was_unread;
      end
      total_in = scan_en ? scan_chain[TABLE_ENTRIES] : total_ff;
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      total_ff <= total_in;
   end

   // response built from the row results at the apply cycle
   always_comb begin
      rsp_count_in  = rsp_count_ff;
      rsp_badge_in  = rsp_badge_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      if (commit) begin
         rsp_valid_in  = 1'b1;
         rsp_count_in  = '0;
         rsp_badge_in  = 1'b0;
         rsp_status_in = ust_pkg::STATUS_MISS;
         case (req_ff.req_type)
            ust_pkg::OP_ARRIVE: begin
               if (req_ff.conversation_open) begin
                  rsp_status_in = ust_pkg::STATUS_MISS;
               end else if (!(total_ff.hit || total_ff.inv || total_ff.zero)) begin
                  // table full, arrival dropped
                  rsp_status_in = ust_pkg::STATUS_FULL;
               end else begin
                  rsp_status_in = ust_pkg::STATUS_DONE;
                  rsp_count_in  = apply_chain[TABLE_ENTRIES].count;
               end
            end
            ust_pkg::OP_CLEAR: begin
               rsp_count_in = apply_chain[TABLE_ENTRIES].count;
               if (total_ff.hit && req_ff.was_unread) begin
                  rsp_status_in = ust_pkg::STATUS_DONE;
               end
            end
            ust_pkg::OP_COUNT: begin
               rsp_count_in = apply_chain[TABLE_ENTRIES].count;
               if (total_ff.hit) begin
                  rsp_status_in = ust_pkg::STATUS_DONE;
               end
            end
            ust_pkg::OP_BADGE: begin
               rsp_badge_in  = apply_chain[TABLE_ENTRIES].badge;
               rsp_status_in = ust_pkg::STATUS_DONE;
            end
            ust_pkg::OP_DELETE: begin
               if (apply_chain[TABLE_ENTRIES].deleted) begin
                  rsp_status_in = ust_pkg::STATUS_DONE;
               end
            end
            default: begin
               rsp_status_in = ust_pkg::STATUS_MISS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff  <= rsp_count_in;
      rsp_badge_ff  <= rsp_badge_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready         = req_ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.msg_count     = rsp_count_ff;
   assign rsp_chan.badge_present = rsp_badge_ff;
   assign rsp_chan.status        = rsp_status_ff;

`ifndef SYNTHESIS
   // keys stay unique, so at most one valid entry matches
   a_single_hit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ust_pkg::ST_APPLY) |-> $onehot0(hit_vec))
      else $error("more than one entry matches the request key");

   // the priority pick touches at most one entry
   a_single_sel : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ust_pkg::ST_APPLY) |-> $onehot0(sel_vec))
      else $error("more than one entry selected");

   // no new request while the row is being scanned
   a_no_accept_in_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ust_pkg::ST_SCAN) |-> !req_ready)
      else $error("request taken during scan cycle");

   // every accepted request goes through a scan cycle next
   a_scan_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ust_pkg::ST_SCAN))
      else $error("accepted request did not enter scan");

   // a response appears only out of an apply cycle
   a_rsp_from_apply : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(commit))
      else $error("response raised without an apply");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_unread_summary_table_top.sv @@
// self-checking testbench for the unread summary table top level
`default_nettype none

module tb_unread_summary_table_top;

   localparam int TABLE_ENTRIES  = 24;
   localparam int OP_CODES       = 8;       // size of the request code space
   localparam int RANDOM_ITEMS   = 380;
   localparam int KEY_POOL       = 36;      // more keys than entries so the table fills
   localparam int GROUP_POOL     = 5;
   localparam int REPEAT_ITEMS   = 16;      // back to back arrivals on one key
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PERCENT   = 9;
   localparam int DRAIN_CYCLES   = 8;

   // one response as the block should return it
   typedef struct packed {
      logic [15:0] count;
      logic        badge;
      logic [1:0]  status;
   } summary_type;

   logic clock = 1'b0;
   logic reset;

   ust_req_if req_bus ();
   ust_rsp_if rsp_bus ();

   unread_summary_table_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // free-running clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the conversation table
   logic        tbl_valid   [TABLE_ENTRIES];
   logic [15:0] tbl_group   [TABLE_ENTRIES];
   logic [31:0] tbl_contact [TABLE_ENTRIES];
   logic [15:0] tbl_count   [TABLE_ENTRIES];
   logic [7:0]  tbl_badges  [TABLE_ENTRIES];

   ust_pkg::request_type pending_reqs [$];  // requests still to be offered
   summary_type expected_summaries [$];     // responses owed by the block, oldest first

   int accepted_reqs = 0;   // request transactions taken so far
   int seen_rsps     = 0;
   int fail_count    = 0;
   int quiet_cycles  = 0;
   int random_start  = 0;   // index of the first random request
   int holdoff_at [2];      // request counts at which the receiver stops for a while
   int holds_done    = 0;
   int holdoff_left  = 0;
   logic calm;

   // a stretch of the random phase in which neither side idles
   assign calm = accepted_reqs >= random_start + 300 && accepted_reqs < random_start + 380;

   // ---------------------------------------------------------------------------
   // table predictor
   // ---------------------------------------------------------------------------

   // valid entry holding both ids, or -1
   function automatic int find_entry(logic [15:0] grp, logic [31:0] who);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (tbl_valid[i] && tbl_group[i] == grp && tbl_contact[i] == who) return i;
      end
      return -1;
   endfunction

   // first invalid entry, else first zero-count entry; -1 when the table is full
   function automatic int take_entry(logic [15:0] grp, logic [31:0] who);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (!tbl_valid[i]) begin
            tbl_valid[i]   = 1'b1;
            tbl_group[i]   = grp;
            tbl_contact[i] = who;
            tbl_count[i]   = 16'd0;
            tbl_badges[i]  = 8'd0;
            return i;
         end
      end
      // reused entries keep their zero count
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (tbl_count[i] == 16'd0) begin
            tbl_valid[i]   = 1'b1;
            tbl_group[i]   = grp;
            tbl_contact[i] = who;
            tbl_badges[i]  = 8'd0;
            return i;
         end
      end
      return -1;
   endfunction

   // applies one request to the shadow table and returns the response it owes
   function automatic summary_type summarize_request(ust_pkg::request_type r);
      summary_type res;
      int          e;
      res.count  = 16'd0;
      res.badge  = 1'b0;
      res.status = ust_pkg::STATUS_MISS;
      case (r.req_type)
         ust_pkg::OP_ARRIVE: begin
            // an open conversation leaves the table alone
            if (!r.conversation_open) begin
               e = find_entry(r.group_id, r.contact_id);
               if (e < 0) e = take_entry(r.group_id, r.contact_id);
               if (e < 0) begin
                  res.status = ust_pkg::STATUS_FULL;
               end else begin
                  if (tbl_count[e] != ust_pkg::COUNT_MAX) tbl_count[e] = tbl_count[e] + 16'd1;
                  tbl_badges[e] = tbl_badges[e] | r.badge_bits;
                  res.count     = tbl_count[e];
                  res.status    = ust_pkg::STATUS_DONE;
               end
            end
         end
         ust_pkg::OP_CLEAR: begin
            e = find_entry(r.group_id, r.contact_id);
            if (e >= 0) begin
               if (r.was_unread) begin
                  if (tbl_count[e] != 16'd0) tbl_count[e] = tbl_count[e] - 16'd1;
                  res.status = ust_pkg::STATUS_DONE;
               end
               res.count = tbl_count[e];
            end
         end
         ust_pkg::OP_COUNT: begin
            e = find_entry(r.group_id, r.contact_id);
            if (e >= 0) begin
               res.count  = tbl_count[e];
               res.status = ust_pkg::STATUS_DONE;
            end
         end
         ust_pkg::OP_BADGE: begin
            res.status = ust_pkg::STATUS_DONE;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (tbl_valid[i] && tbl_count[i] != 16'd0 && (tbl_badges[i] & r.badge_bits) != 8'd0)
                  res.badge = 1'b1;
            end
         end
         ust_pkg::OP_DELETE: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (tbl_valid[i] && tbl_group[i] == r.group_id) begin
                  tbl_valid[i] = 1'b0;
                  res.status   = ust_pkg::STATUS_DONE;
               end
            end
         end
         default: ;  // unused codes are ignored
      endcase
      return res;
   endfunction

   task automatic queue_request(input logic [2:0] op, input logic [15:0] grp,
                                input logic [31:0] who, input logic [7:0] bits,
                                input logic open, input logic unread);
      ust_pkg::request_type r;
      r.req_type          = op;
      r.group_id          = grp;
      r.contact_id        = who;
      r.badge_bits        = bits;
      r.conversation_open = open;
      r.was_unread        = unread;
      pending_reqs.push_back(r);
   endtask

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 10) $display("mismatch at response %0d: %s", seen_rsps, what);
   endtask

   // ---------------------------------------------------------------------------
   // request driver: offers the head of the pending queue, holds it until taken
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      ust_pkg::request_type taken;
      logic                 offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken = pending_reqs.pop_front();
            expected_summaries.push_back(summarize_request(taken));
            accepted_reqs <= accepted_reqs + 1;
         end
         // a stalled transaction stays on the bus unchanged
         if (!(req_bus.valid && !req_bus.ready)) begin
            offer = pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT);
            req_bus.valid <= offer;
            if (offer) begin
               req_bus.req_type          <= pending_reqs[0].req_type;
               req_bus.group_id          <= pending_reqs[0].group_id;
               req_bus.contact_id        <= pending_reqs[0].contact_id;
               req_bus.badge_bits        <= pending_reqs[0].badge_bits;
               req_bus.conversation_open <= pending_reqs[0].conversation_open;
               req_bus.was_unread        <= pending_reqs[0].was_unread;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // long receiver stall: the sender keeps offering so the block backs up
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
         holds_done   <= 0;
      end else if (holds_done < 2 && accepted_reqs >= holdoff_at[holds_done]) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holds_done   <= holds_done + 1;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // ---------------------------------------------------------------------------
   // response monitor: compares each response with the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      summary_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_summaries.size() == 0) begin
               report_mismatch($sformatf("unexpected response count=%0d badge=%0b status=%0d",
                  rsp_bus.msg_count, rsp_bus.badge_present, rsp_bus.status));
            end else begin
               want = expected_summaries.pop_front();
               if (rsp_bus.msg_count !== want.count)
                  report_mismatch($sformatf("msg_count expected %0d actual %0d",
                     want.count, rsp_bus.msg_count));
               if (rsp_bus.badge_present !== want.badge)
                  report_mismatch($sformatf("badge_present expected %0b actual %0b",
                     want.badge, rsp_bus.badge_present));
               if (rsp_bus.status !== want.status)
                  report_mismatch($sformatf("status expected %0d actual %0d",
                     want.status, rsp_bus.status));
            end
            seen_rsps <= seen_rsps + 1;
         end
         rsp_bus.ready <= holdoff_left == 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: too long without any transaction on either channel
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("unread_summary_table_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin
      logic [15:0] grp_pool [GROUP_POOL];
      logic [15:0] key_grp  [KEY_POOL];
      logic [31:0] key_who  [KEY_POOL];
      logic [15:0] g;
      logic [31:0] c;
      logic [2:0]  op;
      int          pick;
      int          k;

      // every input known from time zero
      reset                     = 1'b1;
      req_bus.valid             = 1'b0;
      req_bus.req_type          = ust_pkg::OP_ARRIVE;
      req_bus.group_id          = 16'd0;
      req_bus.contact_id        = 32'd0;
      req_bus.badge_bits        = 8'd0;
      req_bus.conversation_open = 1'b0;
      req_bus.was_unread        = 1'b0;
      rsp_bus.ready             = 1'b0;

      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         tbl_valid[i]   = 1'b0;
         tbl_group[i]   = 16'd0;
         tbl_contact[i] = 32'd0;
         tbl_count[i]   = 16'd0;
         tbl_badges[i]  = 8'd0;
      end

      // directed: empty table, extreme ids, every request code
      queue_request(ust_pkg::OP_COUNT,  16'h0000, 32'h0000_0000, 8'h00, 1'b0, 1'b1); // empty
      queue_request(ust_pkg::OP_CLEAR,  16'h0000, 32'h0000_0000, 8'h00, 1'b0, 1'b1); // no match
      queue_request(ust_pkg::OP_ARRIVE, 16'h0000, 32'h0000_0000, 8'h01, 1'b1, 1'b0); // open
      queue_request(ust_pkg::OP_ARRIVE, 16'h0000, 32'h0000_0000, 8'h01, 1'b0, 1'b0);
      queue_request(ust_pkg::OP_ARRIVE, 16'hFFFF, 32'hFFFF_FFFF, 8'h80, 1'b0, 1'b1);
      queue_request(ust_pkg::OP_ARRIVE, 16'hFFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1);
      queue_request(ust_pkg::OP_COUNT,  16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
      queue_request(ust_pkg::OP_CLEAR,  16'hFFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0); // read
      queue_request(ust_pkg::OP_CLEAR,  16'hFFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1);
      queue_request(ust_pkg::OP_CLEAR,  16'hFFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1);
      queue_request(ust_pkg::OP_CLEAR,  16'hFFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1); // at zero
      queue_request(ust_pkg::OP_BADGE,  16'h0000, 32'h0000_0000, 8'h80, 1'b0, 1'b0); // read entry
      queue_request(ust_pkg::OP_BADGE,  16'h0000, 32'h0000_0000, 8'h01, 1'b0, 1'b0);
      queue_request(ust_pkg::OP_BADGE,  16'hFFFF, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1);
      queue_request(ust_pkg::OP_BADGE,  16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0);
      queue_request(ust_pkg::OP_DELETE, 16'hFFFF, 32'h0000_0000, 8'h00, 1'b0, 1'b0);
      queue_request(ust_pkg::OP_DELETE, 16'hFFFF, 32'h0000_0000, 8'h00, 1'b0, 1'b0); // none left
      queue_request(ust_pkg::OP_COUNT,  16'hFFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0);
      for (int i = ust_pkg::OP_DELETE + 1; i < OP_CODES; i++)
         queue_request(3'(i), 16'($urandom), $urandom, 8'($urandom), 1'($urandom), 1'($urandom));
      queue_request(ust_pkg::OP_DELETE, 16'h0000, 32'h0000_0000, 8'h00, 1'b0, 1'b0);

      // fill every entry, overflow, then reuse a zero-count entry
      for (int i = 0; i < TABLE_ENTRIES; i++)
         queue_request(ust_pkg::OP_ARRIVE, 16'h5A5A, 32'h1000_0000 + i, 8'(1 << (i % 8)),
                       1'b0, 1'b0);
      queue_request(ust_pkg::OP_ARRIVE, 16'h5A5A, 32'h2000_0000, 8'hFF, 1'b0, 1'b0);  // full
      queue_request(ust_pkg::OP_CLEAR,  16'h5A5A, 32'h1000_0003, 8'h00, 1'b0, 1'b1);
      queue_request(ust_pkg::OP_ARRIVE, 16'hA5A5, 32'h2000_0001, 8'h40, 1'b0, 1'b0);  // entry 3
      queue_request(ust_pkg::OP_BADGE,  16'h0000, 32'h0000_0000, 8'h08, 1'b0, 1'b0);
      queue_request(ust_pkg::OP_COUNT,  16'h5A5A, 32'h1000_0003, 8'h00, 1'b0, 1'b0);
      queue_request(ust_pkg::OP_DELETE, 16'h5A5A, 32'h0000_0000, 8'h00, 1'b0, 1'b0);
      queue_request(ust_pkg::OP_DELETE, 16'hA5A5, 32'h0000_0000, 8'h00, 1'b0, 1'b0);

      // a run of arrivals on one key
      for (int i = 0; i < REPEAT_ITEMS; i++)
         queue_request(ust_pkg::OP_ARRIVE, 16'h1234, 32'h8765_4321, 8'($urandom), 1'b0, 1'b0);
      queue_request(ust_pkg::OP_COUNT,  16'h1234, 32'h8765_4321, 8'h00, 1'b0, 1'b0);
      queue_request(ust_pkg::OP_CLEAR,  16'h1234, 32'h8765_4321, 8'h00, 1'b0, 1'b1);
      queue_request(ust_pkg::OP_ARRIVE, 16'h1234, 32'h8765_4321, 8'h00, 1'b0, 1'b0);
      queue_request(ust_pkg::OP_DELETE, 16'h1234, 32'h0000_0000, 8'h00, 1'b0, 1'b0);

      random_start  = pending_reqs.size();
      holdoff_at[0] = 100;
      holdoff_at[1] = random_start + 200;

      // random: keys from a small pool so entries are hit, filled and reused
      for (int i = 0; i < GROUP_POOL; i++) grp_pool[i] = 16'($urandom);
      for (int i = 0; i < KEY_POOL; i++) begin
         key_grp[i] = grp_pool[$urandom_range(0, GROUP_POOL - 1)];
         key_who[i] = $urandom;
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         k    = $urandom_range(0, KEY_POOL - 1);
         if ($urandom_range(0, 9) == 0) begin
            g = 16'($urandom);
            c = $urandom;
         end else begin
            g = key_grp[k];
            c = key_who[k];
         end
         if (pick < 45)      op = ust_pkg::OP_ARRIVE;
         else if (pick < 63) op = ust_pkg::OP_CLEAR;
         else if (pick < 75) op = ust_pkg::OP_COUNT;
         else if (pick < 85) op = ust_pkg::OP_BADGE;
         else if (pick < 91) begin
            op = ust_pkg::OP_DELETE;
            g  = grp_pool[$urandom_range(0, GROUP_POOL - 1)];
         end else            op = 3'($urandom_range(0, OP_CODES - 1));  // noise
         queue_request(op, g, c, 8'($urandom), $urandom_range(0, 9) == 0,
                       $urandom_range(0, 3) != 0);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wait for every request to go out and every response to come back
      while (pending_reqs.size() != 0 || expected_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_summaries.size() == 0) begin
         $display("unread_summary_table_top regression: pass");
      end else begin
         $display("unread_summary_table_top regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ unread_summary_table_top.f @@
rtl/ust_pkg.sv
rtl/ust_if.sv
rtl/ust_cell.sv
rtl/unread_summary_table_top.sv
tb/sv/tb_unread_summary_table_top.sv
